[hdl/hard_pkg.sv]
// ----------------------------------------------------------------------------
// hard_pkg
// Shared types, codes and helpers for the hex archive record deframer.
// ----------------------------------------------------------------------------
package hard_pkg;

  localparam int unsigned LenDigitsDefault = 8;
  localparam int unsigned CharW            = 8;
  localparam int unsigned LenW             = 32;
  localparam int unsigned NibW             = 4;

  typedef enum logic [1:0] {
    PH_NAME_HDR = 2'd0,
    PH_NAME     = 2'd1,
    PH_DATA_HDR = 2'd2,
    PH_DATA     = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_BYTE  = 3'd1,
    KIND_BAD   = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_ODD   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] value;
    logic             last;
  } result_t;

  // {bad, nibble}; anything outside 0-9 and A-F reads as zero and is bad
  function automatic logic [NibW:0] hex_nibble(input logic [CharW-1:0] ch);
    logic [NibW:0] r;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b0, NibW'(ch - 8'h30)};
    end else if (ch inside {[8'h41:8'h46]}) begin
      r = {1'b0, NibW'(ch - 8'h41 + 8'd10)};
    end else begin
      r = {1'b1, {NibW{1'b0}}};
    end
    return r;
  endfunction

endpackage

[hdl/hex_archive_record_deframer_unit.sv]
// ----------------------------------------------------------------------------
// hex_archive_record_deframer_unit
// Walks an archive character stream and emits name characters and data bytes.
// ----------------------------------------------------------------------------
// usage
//   input channel: one archive character per beat on archive_char_i,
//   in_valid_i / in_ready_o handshake
//   output channel: one result per beat on kind_o, value_o, last_o,
//   out_valid_o / out_ready_i handshake; valid header digits (bar the last
//   of an empty data header) and a pair's first digit (bar a lone trailing
//   one) give no result beat; last_o marks the final result of a record
// timing
//   one character per cycle sustained unless a result waits for out_ready_i;
//   a taken character is held in the character register, and its result
//   goes on to the result register that drives the outputs; a single parse
//   step lies between the two registers
// reset
//   rst_ni low clears both registers' valid flags and returns the parser to
//   the name length header of a new record
// stall
//   a held result stays put while out_ready_i is low; the next character
//   still moves on if it makes no result, otherwise it waits in the
//   character register and in_ready_o drops until the result register frees
// ----------------------------------------------------------------------------
module hex_archive_record_deframer_unit import hard_pkg::*; #(
  parameter int unsigned LEN_DIGITS = LenDigitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] archive_char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       kind_o,
  output logic [CharW-1:0] value_o,
  output logic             last_o
);

  // character register
  logic             ch_valid_q, ch_valid_d;
  logic [CharW-1:0] ch_q;

  logic    emit;
  logic    step;
  logic    space;
  result_t res;
  result_t res_q;

  // a character moves on when its result, if any, has a place to go
  assign step       = ch_valid_q && (!emit || space);
  assign in_ready_o = !ch_valid_q || step;
  assign ch_valid_d = (in_valid_i && in_ready_o) || (ch_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_valid_q <= 1'b0;
    end else begin
      ch_valid_q <= ch_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= archive_char_i;
    end
  end

  // parse step: state update and result for the held character
  hard_parse #(
    .LEN_DIGITS (LEN_DIGITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (ch_valid_q),
    .char_i       (ch_q),
    .step_i       (step),
    .emit_o       (emit),
    .res_o        (res)
  );

  // result register toward the receiver
  hard_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && emit),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_q)
  );

  assign kind_o  = res_q.kind;
  assign value_o = res_q.value;
  assign last_o  = res_q.last;

endmodule

[hdl/hard_parse.sv]
// ----------------------------------------------------------------------------
// hard_parse
// Record parser state and the one-character decode step.
// ----------------------------------------------------------------------------
module hard_parse import hard_pkg::*; #(
  parameter int unsigned LEN_DIGITS = LenDigitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic [CharW-1:0] char_i,
  input  logic             step_i,
  output logic             emit_o,
  output result_t          res_o
);

  localparam int unsigned DigW = (LEN_DIGITS > 1) ? $clog2(LEN_DIGITS) : 1;
  localparam logic [DigW-1:0] DigLast = DigW'(LEN_DIGITS - 1);

  phase_e          phase_q, phase_d;
  logic [DigW-1:0] dig_q, dig_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [NibW-1:0] hi_q, hi_d;
  logic            half_q, half_d;
  logic            pbad_q, pbad_d;

  logic            bad;
  logic [NibW-1:0] nib;
  logic [LenW-1:0] acc_shift;
  logic            rem_one;
  logic            emit;
  result_t         res;

  assign {bad, nib} = hex_nibble(char_i);
  assign acc_shift  = {acc_q[LenW-NibW-1:0], nib};
  assign rem_one    = (rem_q == LenW'(1));

  always_comb begin
    phase_d = phase_q;
    dig_d   = dig_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    hi_d    = hi_q;
    half_d  = half_q;
    pbad_d  = pbad_q;
    emit    = 1'b0;
    res     = '{kind: KIND_NAME, value: '0, last: 1'b0};
    case (phase_q)
      PH_NAME_HDR, PH_DATA_HDR: begin
        acc_d = acc_shift;
        if (bad) begin
          emit     = 1'b1;
          res.kind = KIND_BAD;
        end
        if (dig_q == DigLast) begin
          dig_d = '0;
          acc_d = '0;
          if (phase_q == PH_NAME_HDR) begin
            rem_d   = acc_shift;
            phase_d = (acc_shift == '0) ? PH_DATA_HDR : PH_NAME;
          end else if (acc_shift == '0) begin
            // empty data field closes the record
            emit     = 1'b1;
            res.kind = KIND_EMPTY;
            res.last = 1'b1;
            phase_d  = PH_NAME_HDR;
          end else begin
            rem_d   = acc_shift;
            half_d  = 1'b0;
            pbad_d  = 1'b0;
            phase_d = PH_DATA;
          end
        end else begin
          dig_d = DigW'(dig_q + 1'b1);
        end
      end
      PH_NAME: begin
        emit      = 1'b1;
        res.kind  = KIND_NAME;
        res.value = char_i;
        rem_d     = rem_q - LenW'(1);
        if (rem_one) begin
          phase_d = PH_DATA_HDR;
        end
      end
      PH_DATA: begin
        rem_d = rem_q - LenW'(1);
        if (!half_q) begin
          if (rem_one) begin
            // lone trailing digit
            emit     = 1'b1;
            res.kind = KIND_ODD;
            res.last = 1'b1;
            phase_d  = PH_NAME_HDR;
          end else begin
            hi_d   = nib;
            pbad_d = bad;
            half_d = 1'b1;
          end
        end else begin
          emit      = 1'b1;
          res.value = {hi_q, nib};
          res.kind  = (bad || pbad_q) ? KIND_BAD : KIND_BYTE;
          half_d    = 1'b0;
          pbad_d    = 1'b0;
          if (rem_one) begin
            res.last = 1'b1;
            phase_d  = PH_NAME_HDR;
          end
        end
      end
      default: begin
        phase_d = PH_NAME_HDR;
      end
    endcase
  end

  assign emit_o = item_valid_i && emit;
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NAME_HDR;
      dig_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      hi_q    <= '0;
      half_q  <= 1'b0;
      pbad_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      dig_q   <= dig_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      hi_q    <= hi_d;
      half_q  <= half_d;
      pbad_q  <= pbad_d;
    end
  end

`ifndef SYNTHESIS
  a_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NAME || phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("remaining count is zero inside a counted phase");

  a_name_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && phase_q == PH_NAME) |-> (emit_o && res_o.kind == KIND_NAME))
    else $error("name character produced no result");

  a_last_ends_record : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit_o && res_o.last) |=> (phase_q == PH_NAME_HDR && dig_q == '0))
    else $error("record end did not restart at the name header");

  a_half_only_in_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (phase_q == PH_DATA))
    else $error("pair half held outside the data phase");
`endif

endmodule

[hdl/hard_out_reg.sv]
// ----------------------------------------------------------------------------
// hard_out_reg
// Result register with valid/ready hand-off to the downstream side.
// ----------------------------------------------------------------------------
module hard_out_reg import hard_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
